// ----- rtl/assert_macros.svh -----
// Assertion macros for the checker file of this block.
// No dependencies; take it in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that stays quiet while reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed in %m");

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed in %m");

`endif

// ----- rtl/cfdc_pkg.sv -----
// Package of the chute full detector: widths, register indexes, reset values.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package cfdc_pkg;

   localparam int CNT_W      = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int ID_W       = 16;
   localparam int STATUS_W   = 8;

   typedef logic [CNT_W-1:0]      count_type;
   typedef logic [CSR_IDX_W-1:0]  csr_index_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;
   typedef logic [ID_W-1:0]       slave_id_type;
   typedef logic [STATUS_W-1:0]   slave_status_type;

   // Register indexes of the configuration port.
   localparam csr_index_type CSR_FULL_HOLD   = 3'd0;
   localparam csr_index_type CSR_COUNT_AT    = 3'd1;
   localparam csr_index_type CSR_PRESS_HOLD  = 3'd2;
   localparam csr_index_type CSR_LOCKOUT     = 3'd3;
   localparam csr_index_type CSR_BLINK       = 3'd4;
   localparam csr_index_type CSR_SLAVE_BASE  = 3'd5;
   localparam csr_index_type CSR_HORN_ENABLE = 3'd6;

   // Register reset values.
   localparam count_type RST_FULL_HOLD  = 16'd2000;
   localparam count_type RST_COUNT_AT   = 16'd2;
   localparam count_type RST_PRESS_HOLD = 16'd100;
   localparam count_type RST_LOCKOUT    = 16'd3000;
   localparam count_type RST_BLINK      = 16'd500;
   localparam count_type RST_SLAVE_BASE = 16'd300;

   // Input item kinds.
   localparam logic MODE_TICK   = 1'b0;
   localparam logic MODE_REPORT = 1'b1;

endpackage

`default_nettype wire

// ----- rtl/cfdc_req_if.sv -----
// Input channel of the chute full detector: valid, ready and the item fields.
// Depends on cfdc_pkg for the field types.
`default_nettype none

interface cfdc_req_if
   import cfdc_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic             mode;
   logic             sensor_level;
   logic             button_pressed;
   slave_id_type     slave_id;
   slave_status_type slave_status;

   modport source (output valid, output mode, output sensor_level,
                   output button_pressed, output slave_id, output slave_status,
                   input ready);
   modport sink   (input valid, input mode, input sensor_level,
                   input button_pressed, input slave_id, input slave_status,
                   output ready);
endinterface

`default_nettype wire

// ----- rtl/cfdc_rsp_if.sv -----
// Result channel of the chute full detector: valid, ready and the result fields.
// Depends on cfdc_pkg for the field types.
`default_nettype none

interface cfdc_rsp_if
   import cfdc_pkg::*;
   ();
   logic      valid;
   logic      ready;
   logic      chute_full;
   logic      confirmed;
   count_type parcel_count;
   logic      any_board_full;
   logic      status_lamp;
   logic      tower_lamps;
   logic      horn;

   modport source (output valid, output chute_full, output confirmed,
                   output parcel_count, output any_board_full, output status_lamp,
                   output tower_lamps, output horn, input ready);
   modport sink   (input valid, input chute_full, input confirmed,
                   input parcel_count, input any_board_full, input status_lamp,
                   input tower_lamps, input horn, output ready);
endinterface

`default_nettype wire

// ----- rtl/chute_full_detect_confirm.sv -----
// Chute full detector with operator confirmation, lamps and horn.
// Depends on cfdc_pkg and the channel interfaces cfdc_req_if and cfdc_rsp_if.
//
// Usage:
//   req_chan carries one item per handshake. A tick item (mode 0) samples the
//   chute sensor and the button once per millisecond; a report item (mode 1)
//   carries one slave board's identifier and fullness byte.
//   rsp_chan returns exactly one result item for every accepted item, with the
//   chute, confirmation, parcel count, board fullness and lamp/horn drives.
//   The csr_ port writes the seven timing and setup registers; write them only
//   while no item is in flight.
// Latency and throughput:
//   The result of an item is valid in the cycle after it is accepted. The
//   state update is one short pass of counters and compares, so one item is
//   taken in every cycle while rsp_chan.ready is high, one item per clock.
// Stalls:
//   The result register holds its item while rsp_chan.ready is low. A new
//   item is still taken in the cycle the waiting result leaves, so the input
//   resumes as soon as the receiver does; while it stalls, req ready is low.
// Reset:
//   Synchronous reset clears all counters, flags and lamps, empties the result
//   register and loads the register defaults.
`default_nettype none

module chute_full_detect_confirm
   import cfdc_pkg::*;
#(
   parameter int BOARD_COUNT = 8
) (
   input  wire logic          clock,
   input  wire logic          reset,
   cfdc_req_if.sink           req_chan,
   cfdc_rsp_if.source         rsp_chan,
   input  wire logic          csr_write_en,
   input  wire csr_index_type csr_index,
   input  wire csr_data_type  csr_write_data
);

   // Configuration registers.
   count_type full_hold_ff, count_at_ff, press_hold_ff, lockout_ticks_ff;
   count_type blink_ff, slave_base_ff;
   logic      horn_enable_ff;

   // Block state.
   count_type              sensor_ticks_ff, press_ticks_ff, lockout_count_ff, parcels_ff;
   count_type              status_blink_ff, tower_blink_ff;
   logic                   lockout_active_ff, full_ff, confirm_ff, any_full_ff;
   logic                   status_lamp_ff, tower_lamps_ff, horn_ff;
   logic [BOARD_COUNT-1:0] board_full_ff;

   // Next state for the accepted item.
   count_type              sensor_ticks_in, press_ticks_in, lockout_count_in, parcels_in;
   count_type              status_blink_in, tower_blink_in;
   logic                   lockout_active_in, full_in, confirm_in, any_full_in;
   logic                   status_lamp_in, tower_lamps_in, horn_in;
   logic [BOARD_COUNT-1:0] board_full_in;

   logic rsp_valid_ff;
   logic accept;

   // The result register frees up in the same cycle its item is taken.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         full_hold_ff     <= RST_FULL_HOLD;
         count_at_ff      <= RST_COUNT_AT;
         press_hold_ff    <= RST_PRESS_HOLD;
         lockout_ticks_ff <= RST_LOCKOUT;
         blink_ff         <= RST_BLINK;
         slave_base_ff    <= RST_SLAVE_BASE;
         horn_enable_ff   <= 1'b0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_FULL_HOLD:   full_hold_ff     <= csr_write_data;
            CSR_COUNT_AT:    count_at_ff      <= csr_write_data;
            CSR_PRESS_HOLD:  press_hold_ff    <= csr_write_data;
            CSR_LOCKOUT:     lockout_ticks_ff <= csr_write_data;
            CSR_BLINK:       blink_ff         <= csr_write_data;
            CSR_SLAVE_BASE:  slave_base_ff    <= csr_write_data;
            CSR_HORN_ENABLE: horn_enable_ff   <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // One pass over the state for the item at the input. The order follows the
   // tick sequence: blink counters, sensor timing, button, lockout, board
   // summary, then lamps. A report updates at most one slave board flag.
   always_comb begin
      sensor_ticks_in   = sensor_ticks_ff;
      press_ticks_in    = press_ticks_ff;
      lockout_count_in  = lockout_count_ff;
      lockout_active_in = lockout_active_ff;
      parcels_in        = parcels_ff;
      full_in           = full_ff;
      confirm_in        = confirm_ff;
      board_full_in     = board_full_ff;
      any_full_in       = any_full_ff;
      status_blink_in   = status_blink_ff;
      tower_blink_in    = tower_blink_ff;
      status_lamp_in    = status_lamp_ff;
      tower_lamps_in    = tower_lamps_ff;
      horn_in           = horn_ff;

      if (req_chan.mode == MODE_REPORT) begin
         // Board 0 is the local chute and is never matched by a report.
         for (int k = 1; k < BOARD_COUNT; k++) begin
            if (slave_base_ff + CNT_W'(k) == req_chan.slave_id) begin
               board_full_in[k] = (req_chan.slave_status != '0);
            end
         end
      end else begin
         status_blink_in = status_blink_ff + 1'b1;
         tower_blink_in  = tower_blink_ff + 1'b1;

         // Sensor timing is frozen while the operator has confirmed.
         if (!confirm_ff) begin
            if (req_chan.sensor_level) begin
               if (sensor_ticks_ff == full_hold_ff) begin
                  full_in = 1'b1;
               end else begin
                  sensor_ticks_in = sensor_ticks_ff + 1'b1;
                  if (sensor_ticks_in == count_at_ff) begin
                     parcels_in = parcels_ff + 1'b1;
                  end
               end
            end else begin
               sensor_ticks_in = '0;
               full_in         = 1'b0;
            end
            board_full_in[0] = full_in;
         end

         if (req_chan.button_pressed && !lockout_active_ff) begin
            if (full_in) begin
               if (press_ticks_ff == press_hold_ff) begin
                  lockout_active_in = 1'b1;
                  if (!confirm_ff) begin
                     confirm_in       = 1'b1;
                     board_full_in[0] = 1'b0;
                  end else begin
                     confirm_in = 1'b0;
                     parcels_in = '0;
                  end
               end else begin
                  press_ticks_in = press_ticks_ff + 1'b1;
               end
            end else begin
               // A held button on a chute that is not full clears the count.
               parcels_in = '0;
            end
         end else begin
            press_ticks_in = '0;
         end

         // The lockout starts counting on the tick that starts it.
         if (lockout_active_in) begin
            lockout_count_in = lockout_count_ff + 1'b1;
            if (lockout_count_in >= lockout_ticks_ff) begin
               lockout_active_in = 1'b0;
               lockout_count_in  = '0;
            end
         end

         any_full_in = |board_full_in;

         if (full_in) begin
            if (!confirm_in) begin
               if (status_blink_in >= blink_ff) begin
                  status_blink_in = '0;
                  status_lamp_in  = !status_lamp_ff;
               end
            end else begin
               status_lamp_in = 1'b1;
            end
         end else begin
            status_lamp_in = 1'b0;
         end

         // The horn latches on while any board is full, even if disabled later.
         if (any_full_in) begin
            if (horn_enable_ff) begin
               horn_in = 1'b1;
            end
            if (tower_blink_in >= blink_ff) begin
               tower_lamps_in = !tower_lamps_ff;
               tower_blink_in = '0;
            end
         end else begin
            tower_lamps_in = 1'b0;
            horn_in        = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sensor_ticks_ff   <= '0;
         press_ticks_ff    <= '0;
         lockout_count_ff  <= '0;
         lockout_active_ff <= 1'b0;
         parcels_ff        <= '0;
         full_ff           <= 1'b0;
         confirm_ff        <= 1'b0;
         board_full_ff     <= '0;
         any_full_ff       <= 1'b0;
         status_blink_ff   <= '0;
         tower_blink_ff    <= '0;
         status_lamp_ff    <= 1'b0;
         tower_lamps_ff    <= 1'b0;
         horn_ff           <= 1'b0;
      end else if (accept) begin
         sensor_ticks_ff   <= sensor_ticks_in;
         press_ticks_ff    <= press_ticks_in;
         lockout_count_ff  <= lockout_count_in;
         lockout_active_ff <= lockout_active_in;
         parcels_ff        <= parcels_in;
         full_ff           <= full_in;
         confirm_ff        <= confirm_in;
         board_full_ff     <= board_full_in;
         any_full_ff       <= any_full_in;
         status_blink_ff   <= status_blink_in;
         tower_blink_ff    <= tower_blink_in;
         status_lamp_ff    <= status_lamp_in;
         tower_lamps_ff    <= tower_lamps_in;
         horn_ff           <= horn_in;
      end
   end

   // Result register valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // The state registers are loaded only on accept, so they hold the result
   // of the last accepted item for as long as it waits.
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.chute_full     = full_ff;
   assign rsp_chan.confirmed      = confirm_ff;
   assign rsp_chan.parcel_count   = parcels_ff;
   assign rsp_chan.any_board_full = any_full_ff;
   assign rsp_chan.status_lamp    = status_lamp_ff;
   assign rsp_chan.tower_lamps    = tower_lamps_ff;
   assign rsp_chan.horn           = horn_ff;

endmodule

`default_nettype wire

// ----- rtl/cfdc_checker.sv -----
// Port-level checks for the chute full detector, bound to its top level.
// Depends on assert_macros.svh and the top level chute_full_detect_confirm.
`default_nettype none
`include "assert_macros.svh"

module cfdc_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_chute_full,
   input wire logic rsp_confirmed,
   input wire logic rsp_any_board_full,
   input wire logic rsp_horn
);

   `ASSERT_ALWAYS(a_reset_empties, clock, reset |=> !rsp_valid)
   `ASSERT_CLK(a_stall_blocks_input, clock, reset, (rsp_valid && !rsp_ready) |-> !req_ready)
   `ASSERT_CLK(a_accept_gives_result, clock, reset, (req_valid && req_ready) |=> rsp_valid)
   `ASSERT_CLK(a_confirm_needs_full, clock, reset, (rsp_valid && rsp_confirmed) |-> rsp_chute_full)
   `ASSERT_CLK(a_horn_needs_full, clock, reset, (rsp_valid && rsp_horn) |-> rsp_any_board_full)

endmodule

bind chute_full_detect_confirm cfdc_checker u_cfdc_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_chan.valid),
   .req_ready          (req_chan.ready),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_chute_full     (rsp_chan.chute_full),
   .rsp_confirmed      (rsp_chan.confirmed),
   .rsp_any_board_full (rsp_chan.any_board_full),
   .rsp_horn           (rsp_chan.horn)
);

`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking bench for the chute full detector: ticks and slave reports go in,
// status snapshots come out and are checked against the bench model or typed-in values.
// Depends on cfdc_pkg, the cfdc_req_if and cfdc_rsp_if channels and the top level.

module testbench
   import cfdc_pkg::*;
   ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_BOARDS  = 8;
   // The run fails once neither channel has had a handshake for this long; the
   // longest legal quiet stretch is the receiver hold-off.
   localparam int QUIET_LIMIT = 2000;
   localparam int HOLDOFF_CYCLES = 200;
   localparam int IDLE_CHUNK  = 85;

   // One input item as the block sees it.
   typedef struct packed {
      logic             mode;
      logic             sensor_level;
      logic             button_pressed;
      slave_id_type     slave_id;
      slave_status_type slave_status;
   } chute_item_type;

   // One result item: the status snapshot after an input item.
   typedef struct packed {
      logic      chute_full;
      logic      confirmed;
      count_type parcel_count;
      logic      any_board_full;
      logic      status_lamp;
      logic      tower_lamps;
      logic      horn;
   } chute_status_type;

   // Register settings of the block, one field per register.
   typedef struct packed {
      count_type    full_hold;
      count_type    count_at;
      count_type    press_hold;
      count_type    lockout;
      count_type    blink;
      slave_id_type slave_base;
      logic         horn_enable;
   } chute_cfg_type;

   // An item on its way to the block, with a typed-in expectation where the
   // directed table gives one.
   typedef struct packed {
      chute_item_type   item;
      logic             has_status;
      chute_status_type status;
   } chute_offer_type;

   typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_type;

   typedef struct packed {
      row_kind_type    kind;
      chute_offer_type offer;
      int              reps;
      chute_cfg_type   cfg;
   } chute_row_type;

   typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   localparam chute_status_type ALL_QUIET = '0;

   logic          clock;
   logic          reset;
   logic          csr_write_en;
   csr_index_type csr_index;
   csr_data_type  csr_write_data;

   cfdc_req_if req_chan ();
   cfdc_rsp_if rsp_chan ();

   chute_full_detect_confirm #(
      .BOARD_COUNT(NUM_BOARDS)
   ) i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .rsp_chan      (rsp_chan),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_write_data(csr_write_data)
   );

   // ------------------------------------------------------------------------
   // Model of the block. It keeps its own copy of every counter and flag and
   // of the register settings, and advances once per accepted item.
   // ------------------------------------------------------------------------
   chute_cfg_type         cfg;
   count_type             hold_ctr;          // ticks the sensor has been high
   count_type             press_ctr;         // ticks the button has been held
   count_type             lock_ctr;
   logic                  lock_on;
   count_type             parcel_ctr;
   logic                  full_q;
   logic                  confirm_q;
   logic [NUM_BOARDS-1:0] board_flags;       // bit 0 is the local chute
   logic                  any_full_q;
   count_type             status_blink_ctr;
   count_type             tower_blink_ctr;
   logic [2:0]            lamps;             // status lamp, tower lamps, horn

   chute_status_type expected_status_q[$];
   int               error_count;

   // Bench-side drive state.
   chute_offer_type offered;
   idle_mode_type   idle_mode;
   int              holdoff_left;

   // Run state of the random tick generator: current levels and how many
   // ticks each one is still held.
   logic sens_level;
   int   sens_left;
   logic btn_level;
   int   btn_left;

   function automatic chute_cfg_type make_cfg(int fh, int ca, int ph, int lo, int bl,
                                              int base, bit horn);
      chute_cfg_type c;
      c.full_hold   = count_type'(fh);
      c.count_at    = count_type'(ca);
      c.press_hold  = count_type'(ph);
      c.lockout     = count_type'(lo);
      c.blink       = count_type'(bl);
      c.slave_base  = slave_id_type'(base);
      c.horn_enable = horn;
      return c;
   endfunction

   function automatic void reset_model();
      cfg = make_cfg(RST_FULL_HOLD, RST_COUNT_AT, RST_PRESS_HOLD, RST_LOCKOUT,
                     RST_BLINK, RST_SLAVE_BASE, 1'b0);
      hold_ctr         = '0;
      press_ctr        = '0;
      lock_ctr         = '0;
      lock_on          = 1'b0;
      parcel_ctr       = '0;
      full_q           = 1'b0;
      confirm_q        = 1'b0;
      board_flags      = '0;
      any_full_q       = 1'b0;
      status_blink_ctr = '0;
      tower_blink_ctr  = '0;
      lamps            = '0;
   endfunction

   function automatic chute_status_type predict_chute(chute_item_type it);
      chute_status_type st;
      slave_id_type     kid;
      if (it.mode == MODE_REPORT) begin
         // Only slave boards 1 and up can be matched; board 0 is local.
         for (int k = 1; k < NUM_BOARDS; k++) begin
            kid = cfg.slave_base + slave_id_type'(k);
            if (kid == it.slave_id) begin
               board_flags[k] = (it.slave_status != '0);
            end
         end
      end else begin
         status_blink_ctr = status_blink_ctr + 16'd1;
         tower_blink_ctr  = tower_blink_ctr + 16'd1;

         // Sensor timing stops entirely once the operator has confirmed.
         if (!confirm_q) begin
            if (it.sensor_level) begin
               if (hold_ctr == cfg.full_hold) begin
                  full_q = 1'b1;
               end else begin
                  hold_ctr = hold_ctr + 16'd1;
                  if (hold_ctr == cfg.count_at) begin
                     parcel_ctr = parcel_ctr + 16'd1;
                  end
               end
            end else begin
               hold_ctr = '0;
               full_q   = 1'b0;
            end
            board_flags[0] = full_q;
         end

         if (it.button_pressed && !lock_on) begin
            if (full_q) begin
               if (press_ctr == cfg.press_hold) begin
                  lock_on = 1'b1;
                  if (!confirm_q) begin
                     confirm_q      = 1'b1;
                     board_flags[0] = 1'b0;
                  end else begin
                     confirm_q  = 1'b0;
                     parcel_ctr = '0;
                  end
               end else begin
                  press_ctr = press_ctr + 16'd1;
               end
            end else begin
               // A held button on a chute that is not full clears the count.
               parcel_ctr = '0;
            end
         end else begin
            press_ctr = '0;
         end

         if (lock_on) begin
            lock_ctr = lock_ctr + 16'd1;
            if (lock_ctr >= cfg.lockout) begin
               lock_on  = 1'b0;
               lock_ctr = '0;
            end
         end

         any_full_q = |board_flags;

         if (full_q) begin
            if (!confirm_q) begin
               if (status_blink_ctr >= cfg.blink) begin
                  status_blink_ctr = '0;
                  lamps[0]         = ~lamps[0];
               end
            end else begin
               lamps[0] = 1'b1;
            end
         end else begin
            lamps[0] = 1'b0;
         end

         // The horn latches on while any board is full; turning the enable
         // off does not silence it.
         if (any_full_q) begin
            if (cfg.horn_enable) begin
               lamps[2] = 1'b1;
            end
            if (tower_blink_ctr >= cfg.blink) begin
               lamps[1]        = ~lamps[1];
               tower_blink_ctr = '0;
            end
         end else begin
            lamps[2:1] = 2'b00;
         end
      end

      st.chute_full     = full_q;
      st.confirmed      = confirm_q;
      st.parcel_count   = parcel_ctr;
      st.any_board_full = any_full_q;
      st.status_lamp    = lamps[0];
      st.tower_lamps    = lamps[1];
      st.horn           = lamps[2];
      return st;
   endfunction

   // ------------------------------------------------------------------------
   // Clock, and the watchdog that ends a run in which the handshakes stop.
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_chan.valid && req_chan.ready) ||
             (rsp_chan.valid && rsp_chan.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("[chute_full_detect_confirm] ERROR");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Monitor. Both channels are sampled at the rising edge, so the values seen
   // are those the block saw. A result is checked before the item taken at the
   // same edge is predicted, since it belongs to an older item.
   // ------------------------------------------------------------------------
   chute_status_type seen_status;
   chute_status_type want_status;
   chute_item_type   taken_item;
   chute_status_type model_status;

   function automatic bit field_ok(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         return 1'b0;
      end
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen_status.chute_full     = rsp_chan.chute_full;
            seen_status.confirmed      = rsp_chan.confirmed;
            seen_status.parcel_count   = rsp_chan.parcel_count;
            seen_status.any_board_full = rsp_chan.any_board_full;
            seen_status.status_lamp    = rsp_chan.status_lamp;
            seen_status.tower_lamps    = rsp_chan.tower_lamps;
            seen_status.horn           = rsp_chan.horn;
            if (expected_status_q.size() == 0) begin
               $display("%0t: result item with none expected, actual %0h", $time,
                        seen_status);
               error_count++;
            end else begin
               want_status = expected_status_q.pop_front();
               // Bitwise AND so that every wrong field gets its own line.
               if (!(field_ok("chute_full", want_status.chute_full,
                              seen_status.chute_full) &
                     field_ok("confirmed", want_status.confirmed,
                              seen_status.confirmed) &
                     field_ok("parcel_count", want_status.parcel_count,
                              seen_status.parcel_count) &
                     field_ok("any_board_full", want_status.any_board_full,
                              seen_status.any_board_full) &
                     field_ok("status_lamp", want_status.status_lamp,
                              seen_status.status_lamp) &
                     field_ok("tower_lamps", want_status.tower_lamps,
                              seen_status.tower_lamps) &
                     field_ok("horn", want_status.horn, seen_status.horn))) begin
                  error_count++;
               end
            end
         end

         if (req_chan.valid && req_chan.ready) begin
            taken_item.mode           = req_chan.mode;
            taken_item.sensor_level   = req_chan.sensor_level;
            taken_item.button_pressed = req_chan.button_pressed;
            taken_item.slave_id       = req_chan.slave_id;
            taken_item.slave_status   = req_chan.slave_status;
            // The model always advances; a typed-in expectation, where the
            // table has one, takes its place in the queue.
            model_status = predict_chute(taken_item);
            if (offered.has_status) begin
               expected_status_q.push_back(offered.status);
            end else begin
               expected_status_q.push_back(model_status);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver. A hold-off requested by the stimulus wins over random stalls.
   // ------------------------------------------------------------------------
   function automatic bit side_idles(bit sender);
      case (idle_mode)
         IDLE_SENDER:   return sender && ($urandom_range(0, 99) < 60);
         IDLE_RECEIVER: return !sender && ($urandom_range(0, 99) < 60);
         IDLE_BOTH:     return $urandom_range(0, 99) < 26;
         default:       return 1'b0;
      endcase
   endfunction

   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (holdoff_left > 0) begin
            rsp_chan.ready <= 1'b0;
            holdoff_left--;
         end else begin
            rsp_chan.ready <= !side_idles(1'b0);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Sender side tasks. Each is entered just after a rising edge and assigns
   // every signal at most once per edge.
   // ------------------------------------------------------------------------
   task automatic offer_item(input chute_offer_type o);
      while (side_idles(1'b1)) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      offered                 <= o;
      req_chan.valid          <= 1'b1;
      req_chan.mode           <= o.item.mode;
      req_chan.sensor_level   <= o.item.sensor_level;
      req_chan.button_pressed <= o.item.button_pressed;
      req_chan.slave_id       <= o.item.slave_id;
      req_chan.slave_status   <= o.item.slave_status;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // Stop offering and wait until every expected result has come back, then let
   // the registered result path settle. The first edge lets the monitor record
   // an item taken at the edge this task starts on.
   task automatic wait_for_quiet();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (expected_status_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes all seven registers, one per cycle, and updates the model's copy.
   task automatic load_chute_cfg(input chute_cfg_type c);
      csr_write_en <= 1'b1;
      csr_index <= CSR_FULL_HOLD;   csr_write_data <= c.full_hold;      @(posedge clock);
      csr_index <= CSR_COUNT_AT;    csr_write_data <= c.count_at;       @(posedge clock);
      csr_index <= CSR_PRESS_HOLD;  csr_write_data <= c.press_hold;     @(posedge clock);
      csr_index <= CSR_LOCKOUT;     csr_write_data <= c.lockout;        @(posedge clock);
      csr_index <= CSR_BLINK;       csr_write_data <= c.blink;          @(posedge clock);
      csr_index <= CSR_SLAVE_BASE;  csr_write_data <= c.slave_base;     @(posedge clock);
      csr_index <= CSR_HORN_ENABLE; csr_write_data <= csr_data_type'(c.horn_enable);
      @(posedge clock);
      csr_write_en <= 1'b0;
      cfg = c;
   endtask

   // ------------------------------------------------------------------------
   // Directed table helpers. Fields an item kind ignores get random values.
   // ------------------------------------------------------------------------
   function automatic chute_row_type tick_row(bit sensor, bit button, int reps, bit typed);
      chute_row_type r;
      r = '0;
      r.kind                      = ROW_ITEM;
      r.reps                      = reps;
      r.offer.item.mode           = MODE_TICK;
      r.offer.item.sensor_level   = sensor;
      r.offer.item.button_pressed = button;
      r.offer.item.slave_id       = slave_id_type'($urandom);
      r.offer.item.slave_status   = slave_status_type'($urandom);
      r.offer.has_status          = typed;
      r.offer.status              = ALL_QUIET;
      return r;
   endfunction

   function automatic chute_row_type report_row(int id, int status, bit typed);
      chute_row_type r;
      r = '0;
      r.kind                      = ROW_ITEM;
      r.reps                      = 1;
      r.offer.item.mode           = MODE_REPORT;
      r.offer.item.sensor_level   = $urandom_range(0, 1) == 1;
      r.offer.item.button_pressed = $urandom_range(0, 1) == 1;
      r.offer.item.slave_id       = slave_id_type'(id);
      r.offer.item.slave_status   = slave_status_type'(status);
      r.offer.has_status          = typed;
      r.offer.status              = ALL_QUIET;
      return r;
   endfunction

   function automatic chute_row_type cfg_row(chute_cfg_type c);
      chute_row_type r;
      r      = '0;
      r.kind = ROW_CFG;
      r.cfg  = c;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Random stimulus. Most ticks follow runs of sensor and button levels whose
   // lengths straddle hold times of 24 or less, so the chute really fills, gets
   // confirmed and released; some ticks are plain noise.
   // ------------------------------------------------------------------------
   function automatic int run_length(count_type hold);
      if (hold > 24) return $urandom_range(1, 24);
      return $urandom_range(1, int'(hold) + 6);
   endfunction

   function automatic chute_item_type next_random_item();
      chute_item_type it;
      it.sensor_level   = $urandom_range(0, 1) == 1;
      it.button_pressed = $urandom_range(0, 1) == 1;
      it.slave_id       = slave_id_type'($urandom);
      it.slave_status   = slave_status_type'($urandom);
      if ($urandom_range(0, 99) < 20) begin
         it.mode = MODE_REPORT;
         // Aim mostly at the slave identifiers and their neighbors.
         if ($urandom_range(0, 99) < 85) begin
            it.slave_id = cfg.slave_base + slave_id_type'($urandom_range(0, NUM_BOARDS));
         end
         if ($urandom_range(0, 1) == 0) begin
            it.slave_status = '0;
         end
      end else begin
         it.mode = MODE_TICK;
         if ($urandom_range(0, 99) >= 10) begin
            if (sens_left == 0) begin
               sens_level = ~sens_level;
               sens_left  = sens_level ? run_length(cfg.full_hold) : $urandom_range(1, 4);
            end
            if (btn_left == 0) begin
               btn_level = ~btn_level;
               btn_left  = btn_level ? run_length(cfg.press_hold) : $urandom_range(1, 6);
            end
            sens_left--;
            btn_left--;
            it.sensor_level   = sens_level;
            it.button_pressed = btn_level;
         end
      end
      return it;
   endfunction

   function automatic chute_cfg_type mid_cfg();
      int fh;
      fh = $urandom_range(1, 12);
      return make_cfg(fh, $urandom_range(0, fh + 1), $urandom_range(0, 5),
                      $urandom_range(1, 10), $urandom_range(0, 6), $urandom_range(0, 65535),
                      $urandom_range(0, 1) == 1);
   endfunction

   // One random phase: wait for quiet, load the settings, then send items with
   // the idle pattern rotating every chunk. With pressure on, the receiver
   // holds off for a long stretch halfway through while items keep coming.
   task automatic run_phase(input chute_cfg_type c, input int n_items, input bit pressure);
      chute_offer_type o;
      wait_for_quiet();
      load_chute_cfg(c);
      o = '0;
      for (int n = 0; n < n_items; n++) begin
         idle_mode = idle_mode_type'((n / IDLE_CHUNK) % 4);
         if (pressure && n == n_items / 2) begin
            holdoff_left = HOLDOFF_CYCLES;
         end
         o.item = next_random_item();
         offer_item(o);
      end
   endtask

   // ------------------------------------------------------------------------
   // Main sequence.
   // ------------------------------------------------------------------------
   chute_row_type dir_rows[$];

   initial begin
      chute_cfg_type small_cfg;
      error_count  = 0;
      holdoff_left = 0;
      idle_mode    = IDLE_NONE;
      sens_level   = 1'b0;
      sens_left    = 0;
      btn_level    = 1'b0;
      btn_left     = 0;
      reset_model();

      reset                   <= 1'b1;
      csr_write_en            <= 1'b0;
      csr_index               <= CSR_FULL_HOLD;
      csr_write_data          <= '0;
      offered                 <= '0;
      req_chan.valid          <= 1'b0;
      req_chan.mode           <= MODE_TICK;
      req_chan.sensor_level   <= 1'b0;
      req_chan.button_pressed <= 1'b0;
      req_chan.slave_id       <= '0;
      req_chan.slave_status   <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Boards at 0xFFFD..0x0003: the identifier wraps past zero.
      small_cfg = make_cfg(3, 1, 1, 0, 0, 16'hFFFC, 1'b1);

      // Reset settings first. Right after reset the snapshot is all zero, a
      // held button on an empty chute leaves it so, and a report never shows
      // up in the snapshot of its own result.
      dir_rows.push_back(tick_row(1'b0, 1'b0, 1, 1'b1));
      dir_rows.push_back(tick_row(1'b0, 1'b1, 1, 1'b1));
      dir_rows.push_back(report_row(299, 8'hFF, 1'b1));
      dir_rows.push_back(report_row(300, 8'h01, 1'b1));   // base itself is the local board
      dir_rows.push_back(report_row(301, 8'hFF, 1'b1));
      dir_rows.push_back(tick_row(1'b1, 1'b0, 1, 1'b0));
      dir_rows.push_back(report_row(308, 8'h80, 1'b0));   // one past the last board
      dir_rows.push_back(report_row(307, 8'h01, 1'b0));
      dir_rows.push_back(report_row(301, 8'h00, 1'b0));
      dir_rows.push_back(tick_row(1'b1, 1'b0, 1, 1'b0)); // parcel at the count-at tick
      // Short hold times, zero blink period, zero lockout, horn enabled.
      dir_rows.push_back(cfg_row(small_cfg));
      dir_rows.push_back(tick_row(1'b0, 1'b0, 1, 1'b0));
      dir_rows.push_back(tick_row(1'b1, 1'b0, 4, 1'b0)); // chute fills
      dir_rows.push_back(tick_row(1'b1, 1'b1, 3, 1'b0)); // confirm, then release
      dir_rows.push_back(report_row(16'hFFFF, 8'hFF, 1'b0));
      dir_rows.push_back(report_row(16'h0000, 8'h01, 1'b0));
      dir_rows.push_back(report_row(16'h0003, 8'h7F, 1'b0));
      dir_rows.push_back(report_row(16'h0004, 8'h01, 1'b0));
      dir_rows.push_back(report_row(16'hFFFC, 8'h01, 1'b0));
      dir_rows.push_back(tick_row(1'b1, 1'b0, 2, 1'b0));
      // Horn enable dropped: the horn must keep sounding.
      small_cfg.horn_enable = 1'b0;
      dir_rows.push_back(cfg_row(small_cfg));
      dir_rows.push_back(tick_row(1'b1, 1'b0, 2, 1'b0));
      // Hold time lowered below the running sensor count: the count keeps
      // going past it and passes the count-at tick on its way.
      dir_rows.push_back(cfg_row(make_cfg(0, 20, 1, 0, 0, 16'hFFFC, 1'b0)));
      dir_rows.push_back(tick_row(1'b1, 1'b0, 40, 1'b0));
      dir_rows.push_back(tick_row(1'b0, 1'b1, 1, 1'b0));
      // Clearing every slave board finally silences the horn.
      dir_rows.push_back(report_row(16'hFFFF, 8'h00, 1'b0));
      dir_rows.push_back(report_row(16'h0000, 8'h00, 1'b0));
      dir_rows.push_back(report_row(16'h0003, 8'h00, 1'b0));
      dir_rows.push_back(tick_row(1'b0, 1'b0, 2, 1'b0));

      idle_mode = IDLE_BOTH;
      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CFG) begin
            wait_for_quiet();
            load_chute_cfg(dir_rows[i].cfg);
         end else begin
            repeat (dir_rows[i].reps) offer_item(dir_rows[i].offer);
         end
      end

      // Random phases over several settings, both ends of the ranges among them.
      run_phase(mid_cfg(), 340, 1'b0);
      run_phase(make_cfg(65535, 65535, 65535, 65535, 65535, 65535, 1'b1), 200, 1'b0);
      run_phase(make_cfg(0, 0, 0, 1, 0, 0, 1'b1), 340, 1'b0);
      run_phase(mid_cfg(), 340, 1'b1);
      run_phase(mid_cfg(), 340, 1'b0);

      wait_for_quiet();
      if (error_count == 0 && expected_status_q.size() == 0) begin
         $display("[chute_full_detect_confirm] OK");
      end else begin
         $display("[chute_full_detect_confirm] ERROR");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/cfdc_pkg.sv
rtl/cfdc_req_if.sv
rtl/cfdc_rsp_if.sv
rtl/chute_full_detect_confirm.sv
rtl/cfdc_checker.sv
dv/testbench.sv
